### src/pdsp_pkg.sv
// Shared types, constants and helper functions for the pixel downscale,
// swizzle and premultiply block. No dependencies.
`timescale 1ns / 1ps

package pdsp_pkg;

    localparam int DIM_W            = 14;
    localparam int CHAN_W           = 8;
    localparam int FMT_W            = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 14;
    localparam int PROD_W           = 2 * DIM_W;
    localparam int FIFO_DEPTH       = 2;
    localparam int FIFO_CNT_W       = 2;
    localparam int MAX_DIMENSION_DEF = 8192;

    localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = DIM_W'(1080);
    localparam logic [DIM_W-1:0] MAX_WIDTH_RST  = DIM_W'(1600);

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [FMT_W-1:0] {
        FMT_RGBA  = 2'd0,
        FMT_RGBX  = 2'd1,
        FMT_BGRA  = 2'd2,
        FMT_OTHER = 2'd3
    } t_pix_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_MAX_WIDTH  = 2'd2,
        CFG_PIX_FORMAT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_FIT_H  = 2'd0,
        DIV_STEP_W = 2'd1,
        DIV_STEP_H = 2'd2
    } t_div_sel;

    // Controller to datapath
    typedef struct packed {
        logic     capture;     // hold the accepted pixel for later
        logic     step;        // process one pixel and advance counters
        logic     use_held;    // process the held pixel, not the port
        logic     latch_dims;
        logic     load_prod;
        logic     div_start;
        t_div_sel div_sel;
        logic     load_fit_h;
        logic     load_step_w;
        logic     load_step_h;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic frame_start;
        logic out_full;
        logic div_done;
    } t_dp_stat;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              end_of_row;
        logic              end_of_frame;
        logic              format_error;
    } t_result;

    // (c*a + 127) / 255 without a divider: t/255 == (t + (t >> 8) + 1) >> 8
    // over the whole range of t reachable here.
    function automatic logic [CHAN_W-1:0] premul(input logic [CHAN_W-1:0] c,
                                                 input logic [CHAN_W-1:0] a);
        logic [2*CHAN_W:0] t;
        logic [2*CHAN_W:0] s;
        t = (2*CHAN_W+1)'(c * a) + (2*CHAN_W+1)'(127);
        s = t + (t >> CHAN_W) + (2*CHAN_W+1)'(1);
        return s[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

### src/pdsp_pix_in_if.sv
// Source pixel channel: valid/ready handshake with four pixel bytes.
// Depends on pdsp_pkg.
`timescale 1ns / 1ps

interface pdsp_pix_in_if import pdsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan3;

    modport source (output valid, output chan0, output chan1, output chan2,
                    output chan3, input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2,
                    input chan3, output ready);
endinterface

### src/pdsp_pix_out_if.sv
// Result pixel channel: valid/ready handshake with premultiplied color and flags.
// Depends on pdsp_pkg.
`timescale 1ns / 1ps

interface pdsp_pix_out_if import pdsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              end_of_row;
    logic              end_of_frame;
    logic              format_error;

    modport source (output valid, output red, output green, output blue,
                    output end_of_row, output end_of_frame, output format_error,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input end_of_row, input end_of_frame, input format_error,
                    output ready);
endinterface

### src/pdsp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pdsp_pkg for the default widths PROD_W and DIM_W.
`timescale 1ns / 1ps

module pdsp_div import pdsp_pkg::*; #(
    parameter int N_W = PROD_W,
    parameter int D_W = DIM_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quot,
    output logic [D_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_quot;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_dvs;

    logic [D_W:0]     shifted;
    logic             fits;
    logic [D_W:0]     diff;

    always_comb begin
        shifted = {r_rem, r_quot[N_W-1]};
        fits    = shifted >= {1'b0, r_dvs};
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[N_W-2:0], fits};
            r_rem  <= fits ? diff[D_W-1:0] : shifted[D_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

### src/pdsp_dp.sv
// Datapath: configuration registers, frame setup, sampling counters,
// swizzle/premultiply and the two-entry result queue. Depends on pdsp_pkg, pdsp_div.
`timescale 1ns / 1ps

module pdsp_dp import pdsp_pkg::*; #(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CHAN_W-1:0]     i_chan0,
    input  logic [CHAN_W-1:0]     i_chan1,
    input  logic [CHAN_W-1:0]     i_chan2,
    input  logic [CHAN_W-1:0]     i_chan3,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res
);
    // configuration
    logic [DIM_W-1:0] r_cfg_src_w;
    logic [DIM_W-1:0] r_cfg_src_h;
    logic [DIM_W-1:0] r_cfg_max_w;
    t_pix_fmt         r_cfg_fmt;

    // frame geometry and stepping
    logic [DIM_W-1:0]  r_frame_w, n_frame_w;
    logic [DIM_W-1:0]  r_frame_h, n_frame_h;
    logic [DIM_W-1:0]  r_fit_w, n_fit_w;
    logic [DIM_W-1:0]  r_fit_h, n_fit_h;
    logic              r_narrow, n_narrow;
    logic [PROD_W-1:0] r_prod;
    logic [DIM_W-1:0]  r_q_w, n_q_w;
    logic [DIM_W-1:0]  r_r_w, n_r_w;
    logic [DIM_W-1:0]  r_q_h, n_q_h;
    logic [DIM_W-1:0]  r_r_h, n_r_h;

    logic [DIM_W-1:0]  r_src_col, n_src_col;
    logic [DIM_W-1:0]  r_src_row, n_src_row;
    logic [DIM_W-1:0]  r_out_col, n_out_col;
    logic [DIM_W-1:0]  r_out_row, n_out_row;
    logic [DIM_W-1:0]  r_want_col, n_want_col;
    logic [DIM_W-1:0]  r_col_rem, n_col_rem;
    logic [DIM_W-1:0]  r_want_row, n_want_row;
    logic [DIM_W-1:0]  r_row_rem, n_row_rem;

    // held pixel for the frame-start item
    logic [CHAN_W-1:0] r_hold0, r_hold1, r_hold2, r_hold3;

    // result queue
    t_result               r_fifo [FIFO_DEPTH];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    logic [DIM_W-1:0]  fw_eff, fh_eff, mw_eff;
    logic [PROD_W-1:0] div_dividend;
    logic [DIM_W-1:0]  div_divisor;
    logic              div_done;
    logic [PROD_W-1:0] div_q;
    logic [DIM_W-1:0]  div_r;

    logic [CHAN_W-1:0] px0, px1, px2, px3;
    logic [CHAN_W-1:0] red_raw, blue_raw, alpha;
    logic              hit, eor, eof, push, pop;
    t_result           res;
    logic [DIM_W:0]    col_sum, row_sum, src_next;
    logic              col_wrap, row_wrap;
    logic [DIM_W-1:0]  col_rem_nx, row_rem_nx;
    logic [DIM_W-1:0]  want_col_nx, want_row_nx;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] e;
        if (v == '0) begin
            e = DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIMENSION)) begin
            e = DIM_W'(MAX_DIMENSION);
        end else begin
            e = v;
        end
        return e;
    endfunction

    always_comb begin
        fw_eff = eff_dim(r_cfg_src_w);
        fh_eff = eff_dim(r_cfg_src_h);
        mw_eff = eff_dim(r_cfg_max_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_src_w <= SRC_WIDTH_RST;
            r_cfg_src_h <= SRC_HEIGHT_RST;
            r_cfg_max_w <= MAX_WIDTH_RST;
            r_cfg_fmt   <= FMT_RGBA;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:  r_cfg_src_w <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT: r_cfg_src_h <= i_cfg_data[DIM_W-1:0];
                CFG_MAX_WIDTH:  r_cfg_max_w <= i_cfg_data[DIM_W-1:0];
                CFG_PIX_FORMAT: r_cfg_fmt   <= t_pix_fmt'(i_cfg_data[FMT_W-1:0]);
                default: ;
            endcase
        end
    end

    // shared divider for the three setup quotients
    always_comb begin
        case (i_cmd.div_sel)
            DIV_FIT_H: begin
                div_dividend = r_prod;
                div_divisor  = r_frame_w;
            end
            DIV_STEP_W: begin
                div_dividend = PROD_W'(r_frame_w);
                div_divisor  = r_fit_w;
            end
            DIV_STEP_H: begin
                div_dividend = PROD_W'(r_frame_h);
                div_divisor  = r_fit_h;
            end
            default: begin
                div_dividend = r_prod;
                div_divisor  = r_frame_w;
            end
        endcase
    end

    pdsp_div #(
        .N_W (PROD_W),
        .D_W (DIM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // swizzle and premultiply
    always_comb begin
        px0 = i_cmd.use_held ? r_hold0 : i_chan0;
        px1 = i_cmd.use_held ? r_hold1 : i_chan1;
        px2 = i_cmd.use_held ? r_hold2 : i_chan2;
        px3 = i_cmd.use_held ? r_hold3 : i_chan3;
        case (r_cfg_fmt)
            FMT_RGBA: begin
                red_raw = px0; blue_raw = px2; alpha = px3;
            end
            FMT_BGRA: begin
                red_raw = px2; blue_raw = px0; alpha = px3;
            end
            default: begin
                red_raw = px0; blue_raw = px2; alpha = ALPHA_OPAQUE;
            end
        endcase
        hit = (r_out_row < r_fit_h) && (r_src_row == r_want_row) &&
              (r_out_col < r_fit_w) && (r_src_col == r_want_col);
        eor = r_out_col == r_fit_w - DIM_W'(1);
        eof = eor && (r_out_row == r_fit_h - DIM_W'(1));
        res.red          = premul(red_raw, alpha);
        res.green        = premul(px1, alpha);
        res.blue         = premul(blue_raw, alpha);
        res.end_of_row   = eor;
        res.end_of_frame = eof;
        res.format_error = r_cfg_fmt == FMT_OTHER;
    end

    // incremental column/row targets: add the quotient, carry on the remainder
    always_comb begin
        col_sum     = {1'b0, r_col_rem} + {1'b0, r_r_w};
        col_wrap    = col_sum >= {1'b0, r_fit_w};
        col_rem_nx  = col_wrap ? DIM_W'(col_sum - {1'b0, r_fit_w}) : col_sum[DIM_W-1:0];
        want_col_nx = DIM_W'({1'b0, r_want_col} + {1'b0, r_q_w} + (DIM_W+1)'(col_wrap));
        row_sum     = {1'b0, r_row_rem} + {1'b0, r_r_h};
        row_wrap    = row_sum >= {1'b0, r_fit_h};
        row_rem_nx  = row_wrap ? DIM_W'(row_sum - {1'b0, r_fit_h}) : row_sum[DIM_W-1:0];
        want_row_nx = DIM_W'({1'b0, r_want_row} + {1'b0, r_q_h} + (DIM_W+1)'(row_wrap));
        src_next    = {1'b0, r_src_col} + (DIM_W+1)'(1);
    end

    always_comb begin
        n_frame_w  = r_frame_w;
        n_frame_h  = r_frame_h;
        n_fit_w    = r_fit_w;
        n_fit_h    = r_fit_h;
        n_narrow   = r_narrow;
        n_q_w      = r_q_w;
        n_r_w      = r_r_w;
        n_q_h      = r_q_h;
        n_r_h      = r_r_h;
        n_src_col  = r_src_col;
        n_src_row  = r_src_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_want_col = r_want_col;
        n_col_rem  = r_col_rem;
        n_want_row = r_want_row;
        n_row_rem  = r_row_rem;

        if (i_cmd.latch_dims) begin
            n_frame_w = fw_eff;
            n_frame_h = fh_eff;
            n_narrow  = mw_eff < fw_eff;
            n_fit_w   = (mw_eff < fw_eff) ? mw_eff : fw_eff;
        end
        if (i_cmd.load_fit_h) begin
            if (!r_narrow) begin
                n_fit_h = r_frame_h;
            end else if (div_q == '0) begin
                n_fit_h = DIM_W'(1);
            end else begin
                n_fit_h = div_q[DIM_W-1:0];
            end
        end
        if (i_cmd.load_step_w) begin
            n_q_w = div_q[DIM_W-1:0];
            n_r_w = div_r;
        end
        if (i_cmd.load_step_h) begin
            n_q_h      = div_q[DIM_W-1:0];
            n_r_h      = div_r;
            n_out_row  = '0;
            n_want_row = '0;
            n_row_rem  = '0;
            n_out_col  = '0;
            n_want_col = '0;
            n_col_rem  = '0;
        end
        if (i_cmd.step) begin
            if (hit) begin
                n_out_col  = r_out_col + DIM_W'(1);
                n_want_col = want_col_nx;
                n_col_rem  = col_rem_nx;
                if (eor) begin
                    n_out_row  = r_out_row + DIM_W'(1);
                    n_want_row = want_row_nx;
                    n_row_rem  = row_rem_nx;
                end
            end
            // row end: restart the column targets for the next source row
            if (src_next >= {1'b0, r_frame_w}) begin
                n_src_col  = '0;
                n_out_col  = '0;
                n_want_col = '0;
                n_col_rem  = '0;
                if ({1'b0, r_src_row} + (DIM_W+1)'(1) >= {1'b0, r_frame_h}) begin
                    n_src_row = '0;
                end else begin
                    n_src_row = r_src_row + DIM_W'(1);
                end
            end else begin
                n_src_col = src_next[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w  <= '0;
            r_frame_h  <= '0;
            r_fit_w    <= '0;
            r_fit_h    <= '0;
            r_narrow   <= 1'b0;
            r_q_w      <= '0;
            r_r_w      <= '0;
            r_q_h      <= '0;
            r_r_h      <= '0;
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_want_col <= '0;
            r_col_rem  <= '0;
            r_want_row <= '0;
            r_row_rem  <= '0;
        end else begin
            r_frame_w  <= n_frame_w;
            r_frame_h  <= n_frame_h;
            r_fit_w    <= n_fit_w;
            r_fit_h    <= n_fit_h;
            r_narrow   <= n_narrow;
            r_q_w      <= n_q_w;
            r_r_w      <= n_r_w;
            r_q_h      <= n_q_h;
            r_r_h      <= n_r_h;
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_want_col <= n_want_col;
            r_col_rem  <= n_col_rem;
            r_want_row <= n_want_row;
            r_row_rem  <= n_row_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_prod) begin
            r_prod <= PROD_W'(r_frame_h) * PROD_W'(r_fit_w);
        end
        if (i_cmd.capture) begin
            r_hold0 <= i_chan0;
            r_hold1 <= i_chan1;
            r_hold2 <= i_chan2;
            r_hold3 <= i_chan3;
        end
    end

    // result queue
    assign push = i_cmd.step && hit;
    assign pop  = (r_count != '0) && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    assign o_res_valid = r_count != '0;
    assign o_res       = r_fifo[r_rd_ptr];

    always_comb begin
        o_stat.frame_start = (r_src_col == '0) && (r_src_row == '0);
        o_stat.out_full    = r_count == FIFO_CNT_W'(FIFO_DEPTH);
        o_stat.div_done    = div_done;
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FIFO_CNT_W'(FIFO_DEPTH)) |-> !push)
        else $error("result pushed into a full queue");

    a_col_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fit_w != '0) |-> (r_col_rem < r_fit_w))
        else $error("column remainder out of range");

    a_target_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_want_col >= r_out_col)
        else $error("column target behind output column");

    a_src_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_w != '0) |-> (r_src_col < r_frame_w))
        else $error("source column beyond frame width");

endmodule

### src/pdsp_ctrl.sv
// Controller: accepts pixels, runs the frame-start setup sequence on the
// shared divider and issues datapath commands. Depends on pdsp_pkg.
`timescale 1ns / 1ps

module pdsp_ctrl import pdsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_RUN,
        S_DIM,
        S_MUL,
        S_HDIV,
        S_HWAIT,
        S_WDIV,
        S_WWAIT,
        S_RDIV,
        S_RWAIT,
        S_PROC
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    always_comb begin
        o_in_ready = (r_state == S_RUN) && !i_stat.out_full;
        accept     = o_in_ready && i_in_valid;
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.div_sel = DIV_FIT_H;
        case (r_state)
            S_RUN: begin
                if (accept) begin
                    if (i_stat.frame_start) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_DIM;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_DIM: begin
                o_cmd.latch_dims = 1'b1;
                n_state          = S_MUL;
            end
            S_MUL: begin
                o_cmd.load_prod = 1'b1;
                n_state         = S_HDIV;
            end
            S_HDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_HWAIT;
            end
            S_HWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.load_fit_h = 1'b1;
                    n_state          = S_WDIV;
                end
            end
            S_WDIV: begin
                o_cmd.div_sel   = DIV_STEP_W;
                o_cmd.div_start = 1'b1;
                n_state         = S_WWAIT;
            end
            S_WWAIT: begin
                o_cmd.div_sel = DIV_STEP_W;
                if (i_stat.div_done) begin
                    o_cmd.load_step_w = 1'b1;
                    n_state           = S_RDIV;
                end
            end
            S_RDIV: begin
                o_cmd.div_sel   = DIV_STEP_H;
                o_cmd.div_start = 1'b1;
                n_state         = S_RWAIT;
            end
            S_RWAIT: begin
                o_cmd.div_sel = DIV_STEP_H;
                if (i_stat.div_done) begin
                    o_cmd.load_step_h = 1'b1;
                    n_state           = S_PROC;
                end
            end
            S_PROC: begin
                // hold the frame-start pixel until the queue has room
                if (!i_stat.out_full) begin
                    o_cmd.step     = 1'b1;
                    o_cmd.use_held = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/pixel_downscale_swizzle_premultiply.sv
// Nearest-neighbor width fit with RGBA/RGBX/BGRA swizzle and alpha premultiply.
// Pixels are taken one per cycle in raster order while the result queue has room and no
// frame setup is running. The first pixel of each frame is held while the frame setup
// runs three divisions in turn on one shared bit-serial divider (output height, column
// step, row step). A two-entry result queue lets pixels keep flowing while a result waits.
// Dimension registers are sampled when a frame's first pixel arrives.
`timescale 1ns / 1ps

module pixel_downscale_swizzle_premultiply import pdsp_pkg::*; #(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pdsp_pix_in_if.sink           i_pix,
    pdsp_pix_out_if.source        o_pix
);
    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_result  res;
    logic     in_ready;
    logic     res_valid;

    pdsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    pdsp_dp #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_chan0     (i_pix.chan0),
        .i_chan1     (i_pix.chan1),
        .i_chan2     (i_pix.chan2),
        .i_chan3     (i_pix.chan3),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (res_valid),
        .i_res_ready (o_pix.ready),
        .o_res       (res)
    );

    assign i_pix.ready        = in_ready;
    assign o_pix.valid        = res_valid;
    assign o_pix.red          = res.red;
    assign o_pix.green        = res.green;
    assign o_pix.blue         = res.blue;
    assign o_pix.end_of_row   = res.end_of_row;
    assign o_pix.end_of_frame = res.end_of_frame;
    assign o_pix.format_error = res.format_error;

endmodule
